// ----- rtl/btla_pkg.sv -----
// Package for the bakery ticket lock arbiter.
// Holds payload structs, request and status codes, defaults and register map.
// No dependencies.
package btla_pkg;

    localparam int MAX_THREADS_DEF = 8;
    localparam int TICKET_BITS_DEF = 16;

    localparam int ID_W         = 3;
    localparam int TICKET_OUT_W = 16;
    localparam int ACTIVE_W     = 4;
    localparam int APB_ADDR_W   = 3;
    localparam int APB_DATA_W   = 32;

    localparam logic [ACTIVE_W-1:0] ACTIVE_COUNT_RESET = 4'd8;

    // Register index, taken from paddr[2]
    localparam logic REG_ACTIVE_COUNT = 1'b0;

    typedef enum logic {
        REQ_ACQUIRE = 1'b0,
        REQ_RELEASE = 1'b1
    } req_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_RANGE      = 2'd1,
        ST_WAITING    = 2'd2,
        ST_NOT_HOLDER = 2'd3
    } status_t;

    typedef struct packed {
        req_t            req_type;
        logic [ID_W-1:0] thread_id;
    } in_t;

    typedef struct packed {
        status_t                 status;
        logic [TICKET_OUT_W-1:0] ticket;
        logic                    grant_valid;
        logic [ID_W-1:0]         grant_id;
        logic                    ticket_saturated;
    } res_t;

endpackage

// ----- rtl/btla_cfg.sv -----
// APB-style configuration register for the bakery ticket lock arbiter.
// Holds active_count; depends on btla_pkg.
module btla_cfg (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [btla_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [btla_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [btla_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready,
    output logic [btla_pkg::ACTIVE_W-1:0]      active_count
);
    import btla_pkg::*;

    logic [ACTIVE_W-1:0] active_count_reg;
    logic [ACTIVE_W-1:0] active_count_next;
    logic                wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb begin
        active_count_next = active_count_reg;
        if (wr_en && (paddr[2] == REG_ACTIVE_COUNT)) begin
            active_count_next = pwdata[ACTIVE_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_count_reg <= ACTIVE_COUNT_RESET;
        end else begin
            active_count_reg <= active_count_next;
        end
    end

    always_comb begin
        if (paddr[2] == REG_ACTIVE_COUNT) begin
            prdata = APB_DATA_W'(active_count_reg);
        end else begin
            prdata = '0;
        end
    end

    assign active_count = active_count_reg;

endmodule

// ----- rtl/btla_sel_tree.sv -----
// Balanced select tree: finds the least (or largest) valid value and its index.
// Ties go to the lower index. No package dependencies.
module btla_sel_tree #(
    parameter int N        = 8,
    parameter int TW       = 16,
    parameter bit FIND_MAX = 1'b0,
    localparam int P       = 1 << $clog2(N),
    localparam int IW      = $clog2(P)
) (
    input  logic [N-1:0]         vld,
    input  logic [N-1:0][TW-1:0] val,
    output logic                 found,
    output logic [IW-1:0]        idx,
    output logic [TW-1:0]        val_out
);

    logic          nv [2*P-1];
    logic [IW-1:0] ni [2*P-1];
    logic [TW-1:0] nt [2*P-1];

    for (genvar i = 0; i < P; i++) begin : g_leaf
        if (i < N) begin : g_used
            assign nv[P-1+i] = vld[i];
            assign nt[P-1+i] = val[i];
        end else begin : g_pad
            assign nv[P-1+i] = 1'b0;
            assign nt[P-1+i] = '0;
        end
        assign ni[P-1+i] = IW'(i);
    end

    // Left child always covers the lower indices, so a strict compare keeps ties left
    for (genvar j = 0; j < P-1; j++) begin : g_node
        logic better;
        logic pick_r;
        if (FIND_MAX) begin : g_max
            assign better = nt[2*j+2] > nt[2*j+1];
        end else begin : g_min
            assign better = nt[2*j+2] < nt[2*j+1];
        end
        assign pick_r = nv[2*j+2] && (!nv[2*j+1] || better);
        assign nv[j]  = nv[2*j+1] || nv[2*j+2];
        assign ni[j]  = pick_r ? ni[2*j+2] : ni[2*j+1];
        assign nt[j]  = pick_r ? nt[2*j+2] : nt[2*j+1];
    end

    assign found   = nv[0];
    assign idx     = ni[0];
    assign val_out = nt[0];

endmodule

// ----- rtl/btla_engine.sv -----
// Lock state and per-request decision logic of the bakery ticket lock arbiter.
// Depends on btla_pkg and btla_sel_tree.
module btla_engine #(
    parameter int MAX_THREADS = btla_pkg::MAX_THREADS_DEF,
    parameter int TICKET_BITS = btla_pkg::TICKET_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          step,
    input  btla_pkg::in_t                 req,
    input  logic [btla_pkg::ACTIVE_W-1:0] active_count,
    output btla_pkg::res_t                res
);
    import btla_pkg::*;

    localparam int TW = TICKET_BITS;
    localparam int IW = $clog2(1 << $clog2(MAX_THREADS));

    logic [MAX_THREADS-1:0]         wait_reg;
    logic [MAX_THREADS-1:0]         wait_next;
    logic [MAX_THREADS-1:0][TW-1:0] tick_reg;
    logic [MAX_THREADS-1:0][TW-1:0] tick_next;

    logic [MAX_THREADS-1:0] active;
    logic [MAX_THREADS-1:0] other_wait;
    logic [IW-1:0]          idi;
    logic                   in_range;

    logic          a_found;
    logic [IW-1:0] a_idx;
    logic [TW-1:0] a_tick;
    logic          m_found;
    logic [IW-1:0] m_idx;
    logic [TW-1:0] m_tick;

    logic          own_wait;
    logic [TW-1:0] own_tick;
    logic          own_wait_new;
    logic [TW-1:0] own_tick_new;
    logic          own_win_pre;
    logic          own_win_post;
    logic [TW:0]   sum;
    logic          sat;
    logic [TW-1:0] new_tick;
    logic          acq_ok;
    logic          rel_ok;
    logic [IW-1:0] post_idx;
    status_t       status;

    for (genvar k = 0; k < MAX_THREADS; k++) begin : g_mask
        assign active[k]     = 32'(k) < 32'(active_count);
        assign other_wait[k] = active[k] && wait_reg[k] && (32'(k) != 32'(req.thread_id));
    end

    assign in_range = (32'(req.thread_id) < 32'(active_count))
                   && (32'(req.thread_id) < MAX_THREADS);
    assign idi      = IW'(req.thread_id);

    // Best waiting thread other than the requester
    btla_sel_tree #(
        .N        (MAX_THREADS),
        .TW       (TW),
        .FIND_MAX (1'b0)
    ) u_min_tree (
        .vld     (other_wait),
        .val     (tick_reg),
        .found   (a_found),
        .idx     (a_idx),
        .val_out (a_tick)
    );

    // Largest ticket among active threads
    btla_sel_tree #(
        .N        (MAX_THREADS),
        .TW       (TW),
        .FIND_MAX (1'b1)
    ) u_max_tree (
        .vld     (active),
        .val     (tick_reg),
        .found   (m_found),
        .idx     (m_idx),
        .val_out (m_tick)
    );

    assign own_wait = wait_reg[idi];
    assign own_tick = tick_reg[idi];

    // Requester holds the lock if it beats every other waiting thread
    assign own_win_pre = in_range && own_wait
                      && (!a_found || (own_tick < a_tick)
                          || ((own_tick == a_tick) && (idi < a_idx)));

    assign sum      = {1'b0, (m_found ? m_tick : TW'(0))} + (TW+1)'(1);
    assign sat      = sum[TW];
    assign new_tick = sat ? {TW{1'b1}} : sum[TW-1:0];

    always_comb begin
        acq_ok = 1'b0;
        rel_ok = 1'b0;
        if (!in_range) begin
            status = ST_RANGE;
        end else if (req.req_type == REQ_ACQUIRE) begin
            if (own_wait) begin
                status = ST_WAITING;
            end else begin
                status = ST_OK;
                acq_ok = 1'b1;
            end
        end else begin
            if (own_win_pre) begin
                status = ST_OK;
                rel_ok = 1'b1;
            end else begin
                status = ST_NOT_HOLDER;
            end
        end
    end

    always_comb begin
        own_wait_new = own_wait;
        own_tick_new = own_tick;
        if (acq_ok) begin
            own_wait_new = 1'b1;
            own_tick_new = new_tick;
        end else if (rel_ok) begin
            own_wait_new = 1'b0;
            own_tick_new = '0;
        end
    end

    // Grant after this request: only the requester's entry changed
    assign own_win_post = in_range && own_wait_new
                       && (!a_found || (own_tick_new < a_tick)
                           || ((own_tick_new == a_tick) && (idi < a_idx)));
    assign post_idx     = own_win_post ? idi : (a_found ? a_idx : '0);

    always_comb begin
        res.status           = status;
        res.ticket           = acq_ok ? TICKET_OUT_W'(new_tick) : '0;
        res.grant_valid      = own_win_post || a_found;
        res.grant_id         = ID_W'(post_idx);
        res.ticket_saturated = acq_ok && sat;
    end

    always_comb begin
        wait_next = wait_reg;
        tick_next = tick_reg;
        if (step && in_range) begin
            wait_next[idi] = own_wait_new;
            tick_next[idi] = own_tick_new;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wait_reg <= '0;
            tick_reg <= '0;
        end else begin
            wait_reg <= wait_next;
            tick_reg <= tick_next;
        end
    end

    a_acq_sets_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        step && acq_ok |=> wait_reg[$past(idi)])
        else $error("acquired thread not marked waiting");

    a_range_no_change: assert property (@(posedge aclk) disable iff (!aresetn)
        step && (status == ST_RANGE) |=> $stable(wait_reg) && $stable(tick_reg))
        else $error("out-of-range request changed lock state");

    a_grant_is_waiting: assert property (@(posedge aclk) disable iff (!aresetn)
        step && res.grant_valid |=> wait_reg[$past(post_idx)])
        else $error("granted thread is not waiting");

    a_release_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        step && rel_ok |=> !wait_reg[$past(idi)] && (tick_reg[$past(idi)] == '0))
        else $error("release left thread state behind");

endmodule

// ----- rtl/bakery_ticket_lock_arbiter.sv -----
// Top level of the bakery ticket lock arbiter: input register, engine, result
// register and configuration port. Depends on btla_pkg, btla_cfg, btla_engine.
//
//  channel   direction  handshake           payload
//  s_        in         s_valid / s_ready   btla_pkg::in_t  (req_type, thread_id)
//  m_        out        m_valid / m_ready   btla_pkg::res_t (status .. ticket_saturated)
//  apb       in/out     psel/penable/pready active_count at byte address 0
//
// One transaction per cycle sustained while m_ready stays high; an accepted
// request is held in the input register, passes the select trees over the thread
// table and is captured in the result register, which drives m_valid.
// Reset clears waiting flags and tickets at once and sets active_count to 8.
// A stalled result holds in the result register while one more transaction
// waits in the input register.
module bakery_ticket_lock_arbiter #(
    parameter int MAX_THREADS = btla_pkg::MAX_THREADS_DEF,
    parameter int TICKET_BITS = btla_pkg::TICKET_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  btla_pkg::in_t                   s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output btla_pkg::res_t                  m_data,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [btla_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [btla_pkg::APB_DATA_W-1:0] pwdata,
    output logic [btla_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);
    import btla_pkg::*;

    logic                in_valid_reg;
    logic                in_valid_next;
    in_t                 in_data_reg;
    in_t                 in_data_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    res_t                out_data_reg;
    res_t                out_data_next;
    logic                advance;
    logic                s_take;
    res_t                res;
    logic [ACTIVE_W-1:0] active_count;

    btla_cfg u_cfg (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .active_count (active_count)
    );

    btla_engine #(
        .MAX_THREADS (MAX_THREADS),
        .TICKET_BITS (TICKET_BITS)
    ) u_engine (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step         (advance),
        .req          (in_data_reg),
        .active_count (active_count),
        .res          (res)
    );

    // Advance when the result register is free or being drained
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign s_take  = s_valid && s_ready;

    always_comb begin
        in_valid_next  = in_valid_reg;
        in_data_next   = in_data_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (s_take) begin
            in_valid_next = 1'b1;
            in_data_next  = s_data;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        if (advance) begin
            out_valid_next = 1'b1;
            out_data_next  = res;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_data_reg  <= in_data_next;
        out_data_reg <= out_data_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule
